>>> hw/rtl/fssf_pkg.sv
// ----------------------------------------------------------------------------
// Frame store shape fill package
// Shared widths, opcodes and configuration indexes of the drawing engine.
// ----------------------------------------------------------------------------
package fssf_pkg;

  localparam int MAX_WIDTH_DEF  = 128;
  localparam int MAX_HEIGHT_DEF = 128;

  localparam int COORD_W = 8;
  localparam int COLOR_W = 16;

  localparam int S_TDATA_W = 48;
  localparam int S_TUSER_W = 3;
  localparam int M_TDATA_W = 16;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HEIGHT = 1'b1;

  localparam int MUL_W  = 18;
  localparam int PROD_W = 2 * MUL_W;

  typedef enum logic [2:0] {
    OP_CLEAR   = 3'd0,
    OP_PIXEL   = 3'd1,
    OP_CIRCLE  = 3'd2,
    OP_ELLIPSE = 3'd3,
    OP_READ    = 3'd4
  } op_e;

endpackage

>>> hw/rtl/fssf_ram.sv
// ----------------------------------------------------------------------------
// Frame store shape fill RAM
// Simple dual-port RAM, one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module fssf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> hw/rtl/fssf_mul.sv
// ----------------------------------------------------------------------------
// Frame store shape fill multiplier
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module fssf_mul (
  input  logic                               clk_i,
  input  logic signed [fssf_pkg::MUL_W-1:0]  a_i,
  input  logic signed [fssf_pkg::MUL_W-1:0]  b_i,
  output logic signed [fssf_pkg::PROD_W-1:0] p_o
);

  import fssf_pkg::*;

  always_ff @(posedge clk_i) begin
    p_o <= a_i * b_i;
  end

endmodule

>>> hw/rtl/frame_store_shape_fill_top.sv
// ----------------------------------------------------------------------------
// Frame store shape fill
// 16-bit frame store with a drawing engine for clear, pixel, filled circle,
// filled ellipse and read commands.
//
//   channel   direction  payload
//   s_axis    in         tdata: pos_x, pos_y, radius_x, radius_y, color
//                        tuser: opcode
//   m_axis    out        tdata: read_color; tuser: out_of_range
//   cfg       in         register index and write data, no read-back
//
// Clear and shapes: setup steps on the shared multiplier, then a scan of the
// clipped bounding box at one pixel per cycle; an empty clipped box skips
// setup and scan. Pixel goes through address and access states, read adds
// a wait for the RAM data, and rejected commands go straight to the result.
// After reset a clearing pass writes every entry, with s_axis_tready low;
// configuration writes are taken throughout.
// The result register lets the next command in while a result is stalled.
// ----------------------------------------------------------------------------
module frame_store_shape_fill_top #(
  parameter int MAX_WIDTH  = fssf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = fssf_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fssf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [fssf_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // pos_x, pos_y, radius_x, radius_y, color
  input  logic [fssf_pkg::S_TDATA_W-1:0]      s_axis_tdata,
  // opcode
  input  logic [fssf_pkg::S_TUSER_W-1:0]      s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // read_color
  output logic [fssf_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  // out_of_range
  output logic                                m_axis_tuser
);

  import fssf_pkg::*;

  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [3:0] SetupLast = 4'd10;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_BOX, ST_SETUP, ST_SCAN,
    ST_ADDR, ST_ACCESS, ST_RDWAIT, ST_DONE
  } state_e;

  function automatic logic signed [MUL_W-1:0] ext_u8(input logic [7:0] v);
    return $signed({{(MUL_W-8){1'b0}}, v});
  endfunction

  function automatic logic signed [MUL_W-1:0] ext_s11(input logic signed [10:0] v);
    return $signed({{(MUL_W-11){v[10]}}, v});
  endfunction

  function automatic logic signed [MUL_W-1:0] ext_u17(input logic [16:0] v);
    return $signed({{(MUL_W-17){1'b0}}, v});
  endfunction

  state_e state_q;
  logic [AW-1:0] init_q;
  logic [3:0] step_q;

  logic [7:0] act_w_q, act_h_q;
  logic [7:0] w_eff, h_eff;

  op_e op_q;
  logic [7:0] cx_q, cy_q, rx_q, ry_q;
  logic [COLOR_W-1:0] color_q;
  logic fill_all_q;
  logic [7:0] x0_q, x1_q, y0_q, y1_q, x_q, y_q;

  logic [16:0] rx2_q, ry2_q, dx0sq_q, dy0sq_q;
  logic signed [PROD_W-1:0] k_q, t0_q, d0_q, t_q, d_q, s_q, e_q;
  logic signed [PROD_W-1:0] rx2x2, ry2x2;
  logic [AW-1:0] row_base_q;

  logic [COLOR_W-1:0] res_color_q;
  logic res_oor_q;
  logic m_tvalid_q;
  logic [COLOR_W-1:0] m_color_q;
  logic m_oor_q;

  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;

  logic s_accept;
  op_e s_op;
  logic [7:0] s_px, s_py, s_rx, s_ry;
  logic [COLOR_W-1:0] s_color;

  logic signed [10:0] xa, xb, ya, yb, wm1, hm1;
  logic signed [10:0] bx0, bx1, by0, by1;
  logic signed [10:0] dx0, dy0, dxo, dyo;

  logic hit;
  logic [AW-1:0] acc_addr;
  logic mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [COLOR_W-1:0] mem_wdata, mem_rdata;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_w_q <= 8'd128;
      act_h_q <= 8'd128;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ACTIVE_WIDTH:  act_w_q <= cfg_wdata_i;
        CFG_ACTIVE_HEIGHT: act_h_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign w_eff = (int'(act_w_q) > MAX_WIDTH)  ? 8'(MAX_WIDTH)  : act_w_q;
  assign h_eff = (int'(act_h_q) > MAX_HEIGHT) ? 8'(MAX_HEIGHT) : act_h_q;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign s_op          = op_e'(s_axis_tuser);
  assign s_px          = s_axis_tdata[7:0];
  assign s_py          = s_axis_tdata[15:8];
  assign s_rx          = s_axis_tdata[23:16];
  assign s_ry          = s_axis_tdata[31:24];
  assign s_color       = s_axis_tdata[47:32];

  // clipped bounding box
  always_comb begin
    xa  = $signed({3'b000, cx_q}) - $signed({3'b000, rx_q});
    xb  = $signed({3'b000, cx_q}) + $signed({3'b000, rx_q});
    ya  = $signed({3'b000, cy_q}) - $signed({3'b000, ry_q});
    yb  = $signed({3'b000, cy_q}) + $signed({3'b000, ry_q});
    wm1 = $signed({3'b000, w_eff}) - 11'sd1;
    hm1 = $signed({3'b000, h_eff}) - 11'sd1;
    if (op_q == OP_CLEAR) begin
      bx0 = '0;
      by0 = '0;
      bx1 = wm1;
      by1 = hm1;
    end else begin
      bx0 = (xa < 11'sd0) ? 11'sd0 : xa;
      by0 = (ya < 11'sd0) ? 11'sd0 : ya;
      bx1 = (xb > wm1) ? wm1 : xb;
      by1 = (yb > hm1) ? hm1 : yb;
    end
    dx0 = $signed({3'b000, x0_q}) - $signed({3'b000, cx_q});
    dy0 = $signed({3'b000, y0_q}) - $signed({3'b000, cy_q});
    dxo = (dx0 <<< 1) + 11'sd1;
    dyo = (dy0 <<< 1) + 11'sd1;
  end

  assign rx2x2 = $signed({{(PROD_W-18){1'b0}}, rx2_q, 1'b0});
  assign ry2x2 = $signed({{(PROD_W-18){1'b0}}, ry2_q, 1'b0});

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == ST_ADDR) begin
      mul_a = ext_u8(cy_q);
      mul_b = ext_u8(w_eff);
    end else if (state_q == ST_SETUP) begin
      case (step_q)
        4'd0: begin mul_a = ext_u8(rx_q);     mul_b = ext_u8(rx_q);   end
        4'd1: begin mul_a = ext_u8(ry_q);     mul_b = ext_u8(ry_q);   end
        4'd2: begin mul_a = ext_s11(dx0);     mul_b = ext_s11(dx0);   end
        4'd3: begin mul_a = ext_s11(dy0);     mul_b = ext_s11(dy0);   end
        4'd4: begin mul_a = ext_u17(rx2_q);   mul_b = ext_u17(ry2_q); end
        4'd5: begin mul_a = ext_u17(dx0sq_q); mul_b = ext_u17(ry2_q); end
        4'd6: begin mul_a = ext_s11(dxo);     mul_b = ext_u17(ry2_q); end
        4'd7: begin mul_a = ext_u17(dy0sq_q); mul_b = ext_u17(rx2_q); end
        4'd8: begin mul_a = ext_s11(dyo);     mul_b = ext_u17(rx2_q); end
        4'd9: begin mul_a = ext_u8(y0_q);     mul_b = ext_u8(w_eff);  end
        default: ;
      endcase
    end
  end

  fssf_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign hit      = fill_all_q || ((t_q + s_q) <= k_q);
  assign acc_addr = mul_p[AW-1:0] + AW'(cx_q);

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = acc_addr;
    mem_raddr = acc_addr;
    mem_wdata = color_q;
    unique case (state_q)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = init_q;
        mem_wdata = '0;
      end
      ST_SCAN: begin
        mem_we    = hit;
        mem_waddr = row_base_q + AW'(x_q);
      end
      ST_ACCESS: begin
        mem_we = (op_q == OP_PIXEL);
        mem_re = (op_q == OP_READ);
      end
      default: ;
    endcase
  end

  fssf_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      init_q      <= '0;
      step_q      <= '0;
      op_q        <= OP_CLEAR;
      cx_q        <= '0;
      cy_q        <= '0;
      rx_q        <= '0;
      ry_q        <= '0;
      color_q     <= '0;
      fill_all_q  <= 1'b0;
      x0_q        <= '0;
      x1_q        <= '0;
      y0_q        <= '0;
      y1_q        <= '0;
      x_q         <= '0;
      y_q         <= '0;
      rx2_q       <= '0;
      ry2_q       <= '0;
      dx0sq_q     <= '0;
      dy0sq_q     <= '0;
      k_q         <= '0;
      t0_q        <= '0;
      d0_q        <= '0;
      t_q         <= '0;
      d_q         <= '0;
      s_q         <= '0;
      e_q         <= '0;
      row_base_q  <= '0;
      res_color_q <= '0;
      res_oor_q   <= 1'b0;
      m_tvalid_q  <= 1'b0;
      m_color_q   <= '0;
      m_oor_q     <= 1'b0;
    end else begin
      if (m_tvalid_q && m_axis_tready && (state_q != ST_DONE)) begin
        m_tvalid_q <= 1'b0;
      end
      unique case (state_q)
        ST_INIT: begin
          init_q <= init_q + AW'(1);
          if (init_q == AW'(Depth - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_accept) begin
            op_q        <= s_op;
            cx_q        <= s_px;
            cy_q        <= s_py;
            rx_q        <= s_rx;
            ry_q        <= (s_op == OP_CIRCLE) ? s_rx : s_ry;
            color_q     <= s_color;
            fill_all_q  <= (s_op == OP_CLEAR);
            res_color_q <= '0;
            res_oor_q   <= 1'b0;
            unique case (s_op)
              OP_CLEAR, OP_CIRCLE: state_q <= ST_BOX;
              OP_ELLIPSE: begin
                state_q <= ((s_rx == '0) || (s_ry == '0)) ? ST_DONE : ST_BOX;
              end
              OP_PIXEL, OP_READ: begin
                if ((s_px < w_eff) && (s_py < h_eff)) begin
                  state_q <= ST_ADDR;
                end else begin
                  res_oor_q <= 1'b1;
                  state_q   <= ST_DONE;
                end
              end
              default: state_q <= ST_DONE;
            endcase
          end
        end
        ST_BOX: begin
          x0_q   <= bx0[7:0];
          x1_q   <= bx1[7:0];
          y0_q   <= by0[7:0];
          y1_q   <= by1[7:0];
          step_q <= '0;
          state_q <= ((bx1 < bx0) || (by1 < by0)) ? ST_DONE : ST_SETUP;
        end
        ST_SETUP: begin
          step_q <= step_q + 4'd1;
          case (step_q)
            4'd1:  rx2_q   <= mul_p[16:0];
            4'd2:  ry2_q   <= mul_p[16:0];
            4'd3:  dx0sq_q <= mul_p[16:0];
            4'd4:  dy0sq_q <= mul_p[16:0];
            4'd5:  k_q     <= mul_p;
            4'd6: begin
              t0_q <= mul_p;
              t_q  <= mul_p;
            end
            4'd7: begin
              d0_q <= mul_p;
              d_q  <= mul_p;
            end
            4'd8:  s_q     <= mul_p;
            4'd9:  e_q     <= mul_p;
            default: ;
          endcase
          if (step_q == SetupLast) begin
            row_base_q <= mul_p[AW-1:0];
            x_q        <= x0_q;
            y_q        <= y0_q;
            state_q    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (x_q == x1_q) begin
            if (y_q == y1_q) begin
              state_q <= ST_DONE;
            end else begin
              y_q        <= y_q + 8'd1;
              x_q        <= x0_q;
              row_base_q <= row_base_q + AW'(w_eff);
              s_q        <= s_q + e_q;
              e_q        <= e_q + rx2x2;
              t_q        <= t0_q;
              d_q        <= d0_q;
            end
          end else begin
            x_q <= x_q + 8'd1;
            t_q <= t_q + d_q;
            d_q <= d_q + ry2x2;
          end
        end
        ST_ADDR: state_q <= ST_ACCESS;
        ST_ACCESS: state_q <= (op_q == OP_READ) ? ST_RDWAIT : ST_DONE;
        ST_RDWAIT: begin
          res_color_q <= mem_rdata;
          state_q     <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_tvalid_q || m_axis_tready) begin
            m_tvalid_q <= 1'b1;
            m_color_q  <= res_color_q;
            m_oor_q    <= res_oor_q;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_color_q;
  assign m_axis_tuser  = m_oor_q;

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> !s_axis_tready)
    else $error("command accepted while busy");

  a_write_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (32'(mem_waddr) < Depth))
    else $error("frame store write beyond depth");

  a_scan_in_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && mem_we) |->
      (x_q >= x0_q && x_q <= x1_q && y_q >= y0_q && y_q <= y1_q))
    else $error("scan write outside clipped box");

endmodule

>>> sim/frame_store_shape_fill_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame store shape fill checker
// Watches the command, result and register channels, keeps a shadow frame
// store with the active area, predicts one result per accepted command and
// compares every accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module frame_store_shape_fill_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [fssf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [fssf_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                               s_valid_i,
  input  logic                               s_ready_i,
  // pos_x, pos_y, radius_x, radius_y, color
  input  logic [fssf_pkg::S_TDATA_W-1:0]     s_data_i,
  // opcode
  input  logic [fssf_pkg::S_TUSER_W-1:0]     s_user_i,
  input  logic                               m_valid_i,
  input  logic                               m_ready_i,
  // read_color
  input  logic [fssf_pkg::M_TDATA_W-1:0]     m_data_i,
  // out_of_range
  input  logic                               m_user_i,
  output int                                 mismatch_count_o,
  output int                                 outstanding_o
);
  import fssf_pkg::*;

  localparam int DEPTH = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;

  typedef struct packed {
    logic [COLOR_W-1:0] read_color;
    logic               out_of_range;
  } result_t;

  logic [COLOR_W-1:0]    pixels [DEPTH];
  logic [CFG_DATA_W-1:0] area_w;
  logic [CFG_DATA_W-1:0] area_h;
  result_t               expected_results [$];
  int                    mismatches;

  function automatic int visible_w();
    return (int'(area_w) > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(area_w);
  endfunction

  function automatic int visible_h();
    return (int'(area_h) > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(area_h);
  endfunction

  function automatic void fill_region(input int cx, input int cy, input int rx,
                                      input int ry, input bit is_ellipse,
                                      input logic [COLOR_W-1:0] c);
    int     w;
    int     h;
    int     x_lo;
    int     x_hi;
    int     y_lo;
    int     y_hi;
    longint rx2;
    longint ry2;
    longint dx2;
    longint dy2;
    bit     hit;
    w    = visible_w();
    h    = visible_h();
    x_lo = (cx - rx < 0) ? 0 : cx - rx;
    y_lo = (cy - ry < 0) ? 0 : cy - ry;
    x_hi = (cx + rx > w - 1) ? w - 1 : cx + rx;
    y_hi = (cy + ry > h - 1) ? h - 1 : cy + ry;
    rx2  = longint'(rx) * longint'(rx);
    ry2  = longint'(ry) * longint'(ry);
    for (int y = y_lo; y <= y_hi; y++) begin
      dy2 = longint'(y - cy) * longint'(y - cy);
      for (int x = x_lo; x <= x_hi; x++) begin
        dx2 = longint'(x - cx) * longint'(x - cx);
        if (is_ellipse) hit = (dx2 * ry2 + dy2 * rx2 <= rx2 * ry2);
        else hit = (dx2 + dy2 <= rx2);
        if (hit) pixels[y * w + x] = c;
      end
    end
  endfunction

  function automatic result_t run_command(input logic [S_TUSER_W-1:0] op,
                                          input logic [S_TDATA_W-1:0] fields);
    result_t r;
    int      px;
    int      py;
    int      rx;
    int      ry;
    int      w;
    int      h;
    logic [COLOR_W-1:0] c;
    r  = '0;
    px = int'(fields[7:0]);
    py = int'(fields[15:8]);
    rx = int'(fields[23:16]);
    ry = int'(fields[31:24]);
    c  = fields[47:32];
    w  = visible_w();
    h  = visible_h();
    case (op)
      OP_CLEAR: begin
        for (int i = 0; i < w * h; i++) pixels[i] = c;
      end
      OP_PIXEL: begin
        if (px < w && py < h) pixels[py * w + px] = c;
        else r.out_of_range = 1'b1;
      end
      OP_CIRCLE: begin
        fill_region(px, py, rx, rx, 1'b0, c);
      end
      OP_ELLIPSE: begin
        if (rx != 0 && ry != 0) fill_region(px, py, rx, ry, 1'b1, c);
      end
      OP_READ: begin
        if (px < w && py < h) r.read_color = pixels[py * w + px];
        else r.out_of_range = 1'b1;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) pixels[i] = '0;
      area_w = 8'd128;
      area_h = 8'd128;
      expected_results.delete();
      mismatches = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_ACTIVE_WIDTH) area_w = cfg_wdata_i;
        else area_h = cfg_wdata_i;
      end
      if (m_valid_i && m_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, read_color %h out_of_range %b",
                   $time, m_data_i, m_user_i);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (m_data_i !== want.read_color) begin
            $display("%0t: read_color expected %h, actual %h",
                     $time, want.read_color, m_data_i);
            mismatches++;
          end
          if (m_user_i !== want.out_of_range) begin
            $display("%0t: out_of_range expected %b, actual %b",
                     $time, want.out_of_range, m_user_i);
            mismatches++;
          end
        end
      end
      if (s_valid_i && s_ready_i) expected_results.push_back(run_command(s_user_i, s_data_i));
    end
    mismatch_count_o <= mismatches;
    outstanding_o    <= expected_results.size();
  end

endmodule

>>> sim/frame_store_shape_fill_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame store shape fill testbench
// Directed commands at the field extremes, then phases of random drawing,
// pixel and read commands under changing active areas, with random idling
// on both channels. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module frame_store_shape_fill_top_test;
  import fssf_pkg::*;

  localparam logic [S_TUSER_W-1:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [S_TUSER_W-1:0] OP_UNUSED_LAST  = 3'd7;
  localparam int WATCHDOG_LIMIT   = 100000;
  localparam int NUM_PHASES       = 9;
  localparam int RANDOM_PER_PHASE = 64;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  s_valid   = 1'b0;
  logic                  s_ready;
  logic [S_TDATA_W-1:0]  s_data    = '0;
  logic [S_TUSER_W-1:0]  s_user    = '0;
  logic                  m_valid;
  logic                  m_ready   = 1'b0;
  logic [M_TDATA_W-1:0]  m_data;
  logic                  m_user;
  logic                  calm      = 1'b0;
  int                    mismatches;
  int                    outstanding;
  int                    quiet_cycles = 0;
  int                    area_w = 128;
  int                    area_h = 128;

  frame_store_shape_fill_top u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user)
  );

  frame_store_shape_fill_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .s_valid_i        (s_valid),
    .s_ready_i        (s_ready),
    .s_data_i         (s_data),
    .s_user_i         (s_user),
    .m_valid_i        (m_valid),
    .m_ready_i        (m_ready),
    .m_data_i         (m_data),
    .m_user_i         (m_user),
    .mismatch_count_o (mismatches),
    .outstanding_o    (outstanding)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_ready <= calm || ($urandom_range(99) >= 15);
  end

  always @(posedge clk) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_area(input int w, input int h);
    area_w = w;
    area_h = h;
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_ACTIVE_WIDTH;
    cfg_wdata <= w[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_idx   <= CFG_ACTIVE_HEIGHT;
    cfg_wdata <= h[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_command(input logic [S_TUSER_W-1:0] op, input logic [7:0] px,
                              input logic [7:0] py, input logic [7:0] rx,
                              input logic [7:0] ry, input logic [COLOR_W-1:0] c);
    while (!calm && $urandom_range(99) < 15) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_user  <= op;
    s_data  <= {c, ry, rx, py, px};
    do @(posedge clk); while (!s_ready);
  endtask

  // drop valid, then hold until every predicted result has come back
  task automatic wait_idle();
    s_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic send_random_command();
    int pick;
    int span_x;
    int span_y;
    int rmax;
    logic [S_TUSER_W-1:0] op;
    logic [7:0] px;
    logic [7:0] py;
    pick = $urandom_range(99);
    if (pick < 2) op = OP_CLEAR;
    else if (pick < 32) op = OP_PIXEL;
    else if (pick < 52) op = OP_CIRCLE;
    else if (pick < 72) op = OP_ELLIPSE;
    else if (pick < 97) op = OP_READ;
    else op = S_TUSER_W'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
    span_x = (area_w > MAX_WIDTH_DEF ? MAX_WIDTH_DEF : area_w) + 4;
    span_y = (area_h > MAX_HEIGHT_DEF ? MAX_HEIGHT_DEF : area_h) + 4;
    if ($urandom_range(99) < 80) begin
      px = 8'($urandom_range(span_x > 255 ? 255 : span_x));
      py = 8'($urandom_range(span_y > 255 ? 255 : span_y));
    end else begin
      px = 8'($urandom);
      py = 8'($urandom);
    end
    pick = $urandom_range(99);
    rmax = (pick < 90) ? 12 : ((pick < 98) ? 31 : 255);
    send_command(op, px, py, 8'($urandom_range(rmax)), 8'($urandom_range(rmax)),
                 COLOR_W'($urandom));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_command(OP_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 16'hFFFF);
    send_command(OP_PIXEL, 8'd127, 8'd127, 8'd255, 8'd255, 16'hA5A5);
    send_command(OP_PIXEL, 8'd128, 8'd5, 8'd0, 8'd0, 16'h1111);
    send_command(OP_PIXEL, 8'd5, 8'd255, 8'd0, 8'd0, 16'h2222);
    send_command(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0000);
    send_command(OP_READ, 8'd127, 8'd127, 8'd0, 8'd0, 16'hFFFF);
    send_command(OP_READ, 8'd255, 8'd0, 8'd0, 8'd0, 16'h0000);
    send_command(OP_CIRCLE, 8'd64, 8'd64, 8'd0, 8'd9, 16'h1234);
    send_command(OP_READ, 8'd64, 8'd64, 8'd0, 8'd0, 16'h0000);
    send_command(OP_CIRCLE, 8'd0, 8'd0, 8'd5, 8'd0, 16'h0F0F);
    send_command(OP_READ, 8'd3, 8'd4, 8'd0, 8'd0, 16'h0000);
    send_command(OP_CIRCLE, 8'd200, 8'd200, 8'd255, 8'd0, 16'h00FF);
    send_command(OP_ELLIPSE, 8'd10, 8'd10, 8'd0, 8'd5, 16'hDEAD);
    send_command(OP_ELLIPSE, 8'd10, 8'd10, 8'd5, 8'd0, 16'hBEEF);
    send_command(OP_READ, 8'd10, 8'd10, 8'd0, 8'd0, 16'h0000);
    send_command(OP_ELLIPSE, 8'd64, 8'd64, 8'd255, 8'd255, 16'hC3C3);
    send_command(OP_ELLIPSE, 8'd30, 8'd40, 8'd20, 8'd7, 16'h7E57);
    send_command(OP_READ, 8'd50, 8'd40, 8'd0, 8'd0, 16'h0000);
    send_command(OP_READ, 8'd51, 8'd40, 8'd0, 8'd0, 16'h0000);
    for (int op = OP_UNUSED_FIRST; op <= OP_UNUSED_LAST; op++) begin
      send_command(op[S_TUSER_W-1:0], 8'd1, 8'd1, 8'd1, 8'd1, 16'hFFFF);
    end
    send_command(OP_CLEAR, 8'd255, 8'd255, 8'd255, 8'd255, 16'h5A5A);
    send_command(OP_READ, 8'd127, 8'd0, 8'd0, 8'd0, 16'h0000);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: set_area(200, 255);
        1: set_area(1, 1);
        2: set_area(0, 37);
        3: set_area(128, 128);
        4: set_area(64, 32);
        5: set_area(17, 0);
        6: set_area(128, 1);
        7: set_area(100, 200);
        default: set_area(1, 128);
      endcase
      calm <= (phase == 3);
      repeat (RANDOM_PER_PHASE) send_random_command();
    end

    wait_idle();
    repeat (32) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
